@@ rtl/core/csp_pkg.sv @@
// ----------------------------------------------------------------------------
// csp_pkg
// Types, codes and saturation helper shared by the sparse complex product
// accumulator and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package csp_pkg;

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned VAL_W  = 40;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned MAC_W  = 64;
  localparam int unsigned SAT_W  = 66;

  localparam int unsigned GRID_POINTS_DEF  = 4096;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;
  localparam int unsigned ACC_WIDTH_DEF    = 40;

  localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PRESET      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TERM        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ        = 3'd4;

  localparam logic [MODE_W-1:0] CONJ_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] CONJ_FIRST  = 2'd1;
  localparam logic [MODE_W-1:0] CONJ_SECOND = 2'd2;
  localparam logic [MODE_W-1:0] CONJ_IGNORE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] value_re;
    logic signed [VAL_W-1:0] value_im;
    logic [IDX_W-1:0]        out_index;
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic [MODE_W-1:0]       conj_mode;
  } csp_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] out_re;
    logic signed [VAL_W-1:0] out_im;
  } csp_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_ACC,
    S_READ
  } csp_state_e;

  function automatic logic signed [SAT_W-1:0] csp_sat(input logic signed [SAT_W-1:0] v,
                                                      input int unsigned w);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = (SAT_W'(1) << (w - 1)) - SAT_W'(1);
    lo = ~hi;
    if (v > hi) begin
      return hi;
    end else if (v < lo) begin
      return lo;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/complex_sparse_product_accumulate.sv @@
// ----------------------------------------------------------------------------
// complex_sparse_product_accumulate
// Sparse complex product accumulator over two field memories and one
// accumulator memory.
// ----------------------------------------------------------------------------
// Items are taken one at a time. A field load, a preset and any ignored item
// finish on acceptance, in the idle state. A term steps through memory read,
// multiply, product sum, then saturating add and write-back into the
// accumulator memory, with its single read and write port. A read goes via
// the memory read register to the output register, held back while an earlier
// result still waits there. Memory contents are undefined until written.
`default_nettype none

module complex_sparse_product_accumulate
  import csp_pkg::*;
#(
  parameter int unsigned GRID_POINTS  = GRID_POINTS_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH    = ACC_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire csp_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output csp_out_t      out_item_o
);

  localparam int unsigned AW = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
  localparam int unsigned SW = SAMPLE_WIDTH;
  localparam int unsigned PW = 2 * SAMPLE_WIDTH;

  csp_state_e state_q, state_d;

  logic in_acc;
  logic term_ok;
  logic out_load;

  logic [PW-1:0]          f1_mem [GRID_POINTS];
  logic [PW-1:0]          f2_mem [GRID_POINTS];
  logic [2*ACC_WIDTH-1:0] acc_mem [GRID_POINTS];
  logic [PW-1:0]          f1_rd_q, f2_rd_q;
  logic [2*ACC_WIDTH-1:0] acc_rd_q;

  logic                   f1_we, f2_we, acc_we, acc_pre;
  logic [PW-1:0]          fld_wdata;
  logic [AW-1:0]          acc_waddr, acc_raddr;
  logic [2*ACC_WIDTH-1:0] acc_wdata, acc_pre_data, acc_mac_data;

  logic [MODE_W-1:0] mode_q;
  logic [AW-1:0]     oi_q;
  logic              rd_ok_q;

  logic signed [SW-1:0] a_re, a_im, b_re, b_im;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [SAT_W-1:0] rr, ii, ri, ir, pr_sum, pi_sum;
  logic signed [MAC_W-1:0] pr_q, pi_q;
  logic signed [ACC_WIDTH-1:0] acc_re, acc_im;

  csp_out_t out_q;
  logic     out_valid_q;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(GRID_POINTS);
  endfunction

  always_comb begin
    term_ok = (in_item_i.kind == KIND_TERM) && (in_item_i.conj_mode != CONJ_IGNORE) &&
              in_range(in_item_i.out_index) && in_range(in_item_i.first_index) &&
              in_range(in_item_i.second_index);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && term_ok) begin
          state_d = S_MUL;
        end else if (in_acc && (in_item_i.kind == KIND_READ)) begin
          state_d = S_READ;
        end
      end
      S_MUL:  state_d = S_SUM;
      S_SUM:  state_d = S_ACC;
      S_ACC:  state_d = S_IDLE;
      S_READ: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    acc_we     = 1'b0;
    acc_pre    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        acc_pre    = in_acc && (in_item_i.kind == KIND_PRESET) && in_range(in_item_i.index);
        acc_we     = acc_pre;
      end
      S_ACC:  acc_we = 1'b1;
      S_READ: out_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  assign in_acc = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Field writes and term reads
  assign fld_wdata = {SW'(csp_sat(SAT_W'(in_item_i.value_re), SW)),
                      SW'(csp_sat(SAT_W'(in_item_i.value_im), SW))};
  assign f1_we = in_acc && (in_item_i.kind == KIND_LOAD_FIRST) && in_range(in_item_i.index);
  assign f2_we = in_acc && (in_item_i.kind == KIND_LOAD_SECOND) && in_range(in_item_i.index);

  always_ff @(posedge clk_i) begin
    if (f1_we) begin
      f1_mem[AW'(in_item_i.index)] <= fld_wdata;
    end
    if (in_acc && term_ok) begin
      f1_rd_q <= f1_mem[AW'(in_item_i.first_index)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (f2_we) begin
      f2_mem[AW'(in_item_i.index)] <= fld_wdata;
    end
    if (in_acc && term_ok) begin
      f2_rd_q <= f2_mem[AW'(in_item_i.second_index)];
    end
  end

  // Accumulator memory
  assign acc_raddr    = (in_item_i.kind == KIND_READ) ? AW'(in_item_i.index)
                                                      : AW'(in_item_i.out_index);
  assign acc_pre_data = {ACC_WIDTH'(csp_sat(SAT_W'(in_item_i.value_re), ACC_WIDTH)),
                         ACC_WIDTH'(csp_sat(SAT_W'(in_item_i.value_im), ACC_WIDTH))};
  assign acc_re       = $signed(acc_rd_q[2*ACC_WIDTH-1:ACC_WIDTH]);
  assign acc_im       = $signed(acc_rd_q[ACC_WIDTH-1:0]);
  assign acc_mac_data = {ACC_WIDTH'(csp_sat(SAT_W'(acc_re) + SAT_W'(pr_q), ACC_WIDTH)),
                         ACC_WIDTH'(csp_sat(SAT_W'(acc_im) + SAT_W'(pi_q), ACC_WIDTH))};
  assign acc_wdata    = acc_pre ? acc_pre_data : acc_mac_data;
  assign acc_waddr    = acc_pre ? AW'(in_item_i.index) : oi_q;

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (in_acc) begin
      acc_rd_q <= acc_mem[acc_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q  <= in_item_i.conj_mode;
      oi_q    <= AW'(in_item_i.out_index);
      rd_ok_q <= in_range(in_item_i.index);
    end
  end

  // Multiply
  assign a_re = $signed(f1_rd_q[PW-1:SW]);
  assign a_im = $signed(f1_rd_q[SW-1:0]);
  assign b_re = $signed(f2_rd_q[PW-1:SW]);
  assign b_im = $signed(f2_rd_q[SW-1:0]);

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL) begin
      p_rr_q <= a_re * b_re;
      p_ii_q <= a_im * b_im;
      p_ri_q <= a_re * b_im;
      p_ir_q <= a_im * b_re;
    end
  end

  // Product sum
  assign rr = SAT_W'(p_rr_q);
  assign ii = SAT_W'(p_ii_q);
  assign ri = SAT_W'(p_ri_q);
  assign ir = SAT_W'(p_ir_q);

  always_comb begin
    case (mode_q)
      CONJ_FIRST: begin
        pr_sum = rr + ii;
        pi_sum = ri - ir;
      end
      CONJ_SECOND: begin
        pr_sum = rr + ii;
        pi_sum = ir - ri;
      end
      default: begin
        pr_sum = rr - ii;
        pi_sum = ri + ir;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      pr_q <= MAC_W'(csp_sat(pr_sum, MAC_W));
      pi_q <= MAC_W'(csp_sat(pi_sum, MAC_W));
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.out_re <= rd_ok_q ? VAL_W'(csp_sat(SAT_W'(acc_re), VAL_W)) : '0;
      out_q.out_im <= rd_ok_q ? VAL_W'(csp_sat(SAT_W'(acc_im), VAL_W)) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

@@ rtl/core/csp_checker.sv @@
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks for the sparse complex product accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module csp_checker
  import csp_pkg::*;
#(
  parameter int unsigned GRID_POINTS = GRID_POINTS_DEF
) (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_ready_o,
  input wire csp_in_t  in_item_i,
  input wire logic     out_valid_o,
  input wire logic     out_ready_i,
  input wire csp_out_t out_item_o
);

  logic in_acc;
  logic term_live;

  assign in_acc    = in_valid_i && in_ready_o;
  assign term_live = (in_item_i.kind == KIND_TERM) && (in_item_i.conj_mode != CONJ_IGNORE) &&
                     (32'(in_item_i.out_index) < 32'(GRID_POINTS)) &&
                     (32'(in_item_i.first_index) < 32'(GRID_POINTS)) &&
                     (32'(in_item_i.second_index) < 32'(GRID_POINTS));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.kind != KIND_READ) && !out_valid_o |=> !out_valid_o)
    else $error("result item without a read");

  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_item_i.kind == KIND_READ) && !out_valid_o |=> !out_valid_o ##1 out_valid_o)
    else $error("read result not delivered on time");

  a_term_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && term_live |=> !in_ready_o ##1 !in_ready_o ##1 !in_ready_o ##1 in_ready_o)
    else $error("term sequence length wrong");

endmodule

bind complex_sparse_product_accumulate csp_checker #(
  .GRID_POINTS(GRID_POINTS)
) u_csp_checker (.*);

`default_nettype wire
